// ----- hw/rtl/onl_pkg.sv -----
// Shared types, constants and character decoders for the operator/number lexer.
// No dependencies; every other lexer file refers to this package by scoped names.
`default_nettype none

package onl_pkg;

  localparam int unsigned OffsetBits = 16;
  localparam int unsigned ValueBits  = 63;
  localparam int unsigned FieldBits  = 16;
  localparam int unsigned ResQDepth  = 4;
  localparam int unsigned ResQIdxBits = $clog2(ResQDepth);
  localparam int unsigned ResQCntBits = $clog2(ResQDepth + 1);

  typedef logic [OffsetBits-1:0] offset_t;
  typedef logic [ValueBits-1:0]  value_t;
  typedef logic [FieldBits-1:0]  field_t;

  typedef enum logic [1:0] {
    KindNumber = 2'd0,
    KindSymbol = 2'd1,
    KindEnd    = 2'd2,
    KindError  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ModeIdle = 2'd0,
    ModeSym  = 2'd1,
    ModeNum  = 2'd2
  } mode_e;

  typedef enum logic [5:0] {
    SymIncr      = 6'd0,
    SymAddAsgn   = 6'd1,
    SymPlus      = 6'd2,
    SymDecr      = 6'd3,
    SymSubAsgn   = 6'd4,
    SymArrow     = 6'd5,
    SymMinus     = 6'd6,
    SymPow       = 6'd7,
    SymMulAsgn   = 6'd8,
    SymStar      = 6'd9,
    SymDblSlash  = 6'd10,
    SymDivAsgn   = 6'd11,
    SymSlash     = 6'd12,
    SymDblPct    = 6'd13,
    SymModAsgn   = 6'd14,
    SymPercent   = 6'd15,
    SymShl       = 6'd16,
    SymLe        = 6'd17,
    SymLt        = 6'd18,
    SymShr       = 6'd19,
    SymGe        = 6'd20,
    SymGt        = 6'd21,
    SymEq        = 6'd22,
    SymFatArrow  = 6'd23,
    SymAssign    = 6'd24,
    SymNe        = 6'd25,
    SymBang      = 6'd26,
    SymLParen    = 6'd27,
    SymRParen    = 6'd28,
    SymLBrace    = 6'd29,
    SymRBrace    = 6'd30,
    SymLBrack    = 6'd31,
    SymRBrack    = 6'd32,
    SymComma     = 6'd33,
    SymSemi      = 6'd34,
    SymColon     = 6'd35,
    SymDot       = 6'd36
  } sym_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       is_end;
  } in_word_t;

  typedef struct packed {
    kind_e               token_kind;
    logic [5:0]          symbol_code;
    value_t              number_value;
    field_t              start_offset;
    field_t              token_length;
    logic                last_result;
  } out_word_t;

  // Lexer state carried from one character to the next
  typedef struct packed {
    mode_e      mode;
    logic [7:0] first_char;
    value_t     accum;
    offset_t    start;
    field_t     len;
    offset_t    offset;
  } lex_state_t;

  typedef struct packed {
    logic hit;
    sym_e code;
  } sym_hit_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic can_pair(logic [7:0] c);
    return (c == "+") || (c == "-") || (c == "*") || (c == "/") || (c == "%") ||
           (c == "<") || (c == ">") || (c == "=") || (c == "!");
  endfunction

  function automatic sym_hit_t single_code(logic [7:0] c);
    sym_hit_t r;
    r.hit = 1'b1;
    unique case (c)
      "+":     r.code = SymPlus;
      "-":     r.code = SymMinus;
      "*":     r.code = SymStar;
      "/":     r.code = SymSlash;
      "%":     r.code = SymPercent;
      "<":     r.code = SymLt;
      ">":     r.code = SymGt;
      "=":     r.code = SymAssign;
      "!":     r.code = SymBang;
      "(":     r.code = SymLParen;
      ")":     r.code = SymRParen;
      "{":     r.code = SymLBrace;
      "}":     r.code = SymRBrace;
      "[":     r.code = SymLBrack;
      "]":     r.code = SymRBrack;
      ",":     r.code = SymComma;
      ";":     r.code = SymSemi;
      ":":     r.code = SymColon;
      ".":     r.code = SymDot;
      default: begin
        r.hit  = 1'b0;
        r.code = SymIncr;
      end
    endcase
    return r;
  endfunction

  function automatic sym_hit_t pair_code(logic [7:0] a, logic [7:0] b);
    sym_hit_t r;
    r.hit  = 1'b1;
    r.code = SymIncr;
    unique case (a)
      "+": begin
        if (b == "+") r.code = SymIncr;
        else if (b == "=") r.code = SymAddAsgn;
        else r.hit = 1'b0;
      end
      "-": begin
        if (b == "-") r.code = SymDecr;
        else if (b == "=") r.code = SymSubAsgn;
        else if (b == ">") r.code = SymArrow;
        else r.hit = 1'b0;
      end
      "*": begin
        if (b == "*") r.code = SymPow;
        else if (b == "=") r.code = SymMulAsgn;
        else r.hit = 1'b0;
      end
      "/": begin
        if (b == "/") r.code = SymDblSlash;
        else if (b == "=") r.code = SymDivAsgn;
        else r.hit = 1'b0;
      end
      "%": begin
        if (b == "%") r.code = SymDblPct;
        else if (b == "=") r.code = SymModAsgn;
        else r.hit = 1'b0;
      end
      "<": begin
        if (b == "<") r.code = SymShl;
        else if (b == "=") r.code = SymLe;
        else r.hit = 1'b0;
      end
      ">": begin
        if (b == ">") r.code = SymShr;
        else if (b == "=") r.code = SymGe;
        else r.hit = 1'b0;
      end
      "=": begin
        if (b == "=") r.code = SymEq;
        else if (b == ">") r.code = SymFatArrow;
        else r.hit = 1'b0;
      end
      "!": begin
        if (b == "=") r.code = SymNe;
        else r.hit = 1'b0;
      end
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

  // Clamp an offset to the 16-bit result field
  function automatic field_t sat_field(offset_t v);
    logic [31:0] w;
    w = 32'(v);
    return (w > 32'h0000_FFFF) ? '1 : w[FieldBits-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/onl_step.sv -----
// Combinational lexer step: one character plus the held state gives up to two
// result words and the next state. Depends on onl_pkg.
`default_nettype none

module onl_step (
  input  onl_pkg::in_word_t   word_i,
  input  onl_pkg::lex_state_t st_i,
  output onl_pkg::lex_state_t st_o,
  output logic [1:0]          res_valid_o,
  output onl_pkg::out_word_t  res0_o,
  output onl_pkg::out_word_t  res1_o
);

  logic [7:0]          c;
  logic [3:0]          digit;
  onl_pkg::sym_hit_t   pair_hit;
  onl_pkg::sym_hit_t   one_hit;
  onl_pkg::sym_hit_t   held_hit;
  onl_pkg::out_word_t  flush_r;
  onl_pkg::out_word_t  fresh_r;
  onl_pkg::out_word_t  pair_r;
  onl_pkg::out_word_t  end_r;
  logic                flush_v;
  logic                fresh_v;
  logic [66:0]         acc_sum;
  onl_pkg::value_t     acc_next;
  onl_pkg::field_t     len_next;
  onl_pkg::offset_t    offset_next;
  onl_pkg::field_t     pos_f;

  assign c        = word_i.ch;
  assign digit    = 4'(c - "0");
  assign pair_hit = onl_pkg::pair_code(st_i.first_char, c);
  assign one_hit  = onl_pkg::single_code(c);
  assign held_hit = onl_pkg::single_code(st_i.first_char);
  assign pos_f    = onl_pkg::sat_field(st_i.offset);

  // accum * 10 + digit; anything above bit 62 saturates
  assign acc_sum  = 67'({st_i.accum, 3'b000}) + 67'({st_i.accum, 1'b0}) + 67'(digit);
  assign acc_next = (|acc_sum[66:onl_pkg::ValueBits]) ? '1 : acc_sum[onl_pkg::ValueBits-1:0];
  assign len_next = (st_i.len == '1) ? st_i.len : st_i.len + 1'b1;
  assign offset_next = (st_i.offset == '1) ? st_i.offset : st_i.offset + 1'b1;

  always_comb begin
    flush_v              = st_i.mode != onl_pkg::ModeIdle;
    flush_r              = '0;
    flush_r.start_offset = onl_pkg::sat_field(st_i.start);
    if (st_i.mode == onl_pkg::ModeNum) begin
      flush_r.token_kind   = onl_pkg::KindNumber;
      flush_r.number_value = st_i.accum;
      flush_r.token_length = st_i.len;
    end else begin
      flush_r.token_kind   = onl_pkg::KindSymbol;
      flush_r.symbol_code  = held_hit.hit ? 6'(held_hit.code) : 6'(onl_pkg::SymIncr);
      flush_r.token_length = onl_pkg::FieldBits'(1);
    end

    fresh_v              = !(onl_pkg::is_space(c) || onl_pkg::is_digit(c) ||
                             onl_pkg::can_pair(c));
    fresh_r              = '0;
    fresh_r.start_offset = pos_f;
    fresh_r.token_length = onl_pkg::FieldBits'(1);
    if (one_hit.hit) begin
      fresh_r.token_kind  = onl_pkg::KindSymbol;
      fresh_r.symbol_code = 6'(one_hit.code);
    end else begin
      fresh_r.token_kind  = onl_pkg::KindError;
    end

    pair_r              = '0;
    pair_r.token_kind   = onl_pkg::KindSymbol;
    pair_r.symbol_code  = 6'(pair_hit.code);
    pair_r.start_offset = onl_pkg::sat_field(st_i.start);
    pair_r.token_length = onl_pkg::FieldBits'(2);

    end_r              = '0;
    end_r.token_kind   = onl_pkg::KindEnd;
    end_r.start_offset = pos_f;
    end_r.token_length = onl_pkg::FieldBits'(1);
  end

  always_comb begin
    st_o        = st_i;
    res_valid_o = 2'b00;
    res0_o      = '0;
    res1_o      = '0;

    if (word_i.is_end) begin
      st_o = '0;
      if (flush_v) begin
        res0_o      = flush_r;
        res1_o      = end_r;
        res_valid_o = 2'b11;
      end else begin
        res0_o      = end_r;
        res_valid_o = 2'b01;
      end
    end else begin
      st_o.offset = offset_next;
      if (st_i.mode == onl_pkg::ModeSym && pair_hit.hit) begin
        res0_o      = pair_r;
        res_valid_o = 2'b01;
        st_o.mode   = onl_pkg::ModeIdle;
      end else if (st_i.mode == onl_pkg::ModeNum && onl_pkg::is_digit(c)) begin
        st_o.accum = acc_next;
        st_o.len   = len_next;
      end else begin
        // held token (if any) goes out, then the character starts over
        st_o.mode = onl_pkg::ModeIdle;
        if (onl_pkg::is_digit(c)) begin
          st_o.mode  = onl_pkg::ModeNum;
          st_o.accum = onl_pkg::ValueBits'(digit);
          st_o.start = st_i.offset;
          st_o.len   = onl_pkg::FieldBits'(1);
        end else if (onl_pkg::can_pair(c)) begin
          st_o.mode       = onl_pkg::ModeSym;
          st_o.first_char = c;
          st_o.start      = st_i.offset;
          st_o.len        = onl_pkg::FieldBits'(1);
        end
        if (flush_v) begin
          res0_o         = flush_r;
          res1_o         = fresh_r;
          res_valid_o[0] = 1'b1;
          res_valid_o[1] = fresh_v;
        end else begin
          res0_o         = fresh_r;
          res_valid_o[0] = fresh_v;
        end
      end
    end

    if (res_valid_o[1]) begin
      res1_o.last_result = 1'b1;
    end else if (res_valid_o[0]) begin
      res0_o.last_result = 1'b1;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/onl_resq.sv -----
// Result queue: takes up to two words per cycle, hands out one per cycle while out_stall_i is low.
// Depends on onl_pkg.
`default_nettype none

module onl_resq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [1:0]          push_i,
  input  onl_pkg::out_word_t  push0_i,
  input  onl_pkg::out_word_t  push1_i,
  output logic                room2_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output onl_pkg::out_word_t  out_word_o
);

  onl_pkg::out_word_t                  mem_q [onl_pkg::ResQDepth];
  logic [onl_pkg::ResQIdxBits-1:0]     wr_q, wr_d, rd_q, rd_d, wr_nxt;
  logic [onl_pkg::ResQCntBits-1:0]     cnt_q, cnt_d;
  logic                                pop;

  assign wr_nxt      = wr_q + 1'b1;
  assign pop         = out_valid_o && !out_stall_i;
  assign out_valid_o = cnt_q != '0;
  assign out_word_o  = mem_q[rd_q];
  assign room2_o     = cnt_q <= onl_pkg::ResQCntBits'(onl_pkg::ResQDepth - 2);

  always_comb begin
    wr_d  = wr_q + onl_pkg::ResQIdxBits'(push_i[0]) + onl_pkg::ResQIdxBits'(push_i[1]);
    rd_d  = rd_q + onl_pkg::ResQIdxBits'(pop);
    cnt_d = cnt_q + onl_pkg::ResQCntBits'(push_i[0]) + onl_pkg::ResQCntBits'(push_i[1])
            - onl_pkg::ResQCntBits'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i[0]) begin
      mem_q[wr_q] <= push0_i;
    end
    if (push_i[1]) begin
      mem_q[wr_nxt] <= push1_i;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/operator_number_lexer.sv -----
// Top level of the streaming operator/number lexer: input register, lexer state,
// step logic and result queue. Depends on onl_pkg, onl_step and onl_resq.
`default_nettype none

// One source byte per cycle unless the input stalls. A byte is captured in the
// input register, lexed in the next cycle against the held state, and its zero,
// one or two tokens enter a four-word result queue at the edge where the byte
// leaves the input register; the output is read from that queue. The output side
// moves one token word per cycle while out_stall_i is low; the input stalls while
// the queue could not absorb two more words, so bytes that each yield two tokens
// are paced by the queue draining once it fills.
// Offsets count bytes since reset or the last end word.
module operator_number_lexer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  onl_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output onl_pkg::out_word_t out_word_o
);

  logic                valid_q;
  onl_pkg::in_word_t   word_q;
  onl_pkg::lex_state_t st_q, st_d;
  logic [1:0]          res_valid;
  onl_pkg::out_word_t  res0, res1;
  logic                room2;
  logic                take;
  logic                load;

  assign take       = valid_q && room2;
  assign load       = !valid_q || take;
  assign in_stall_o = !load;

  onl_step u_step (
    .word_i      (word_q),
    .st_i        (st_q),
    .st_o        (st_d),
    .res_valid_o (res_valid),
    .res0_o      (res0),
    .res1_o      (res1)
  );

  onl_resq u_resq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (take ? res_valid : 2'b00),
    .push0_i     (res0),
    .push1_i     (res1),
    .room2_o     (room2),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      st_q    <= '0;
    end else begin
      if (load) begin
        valid_q <= in_valid_i;
      end
      if (take) begin
        st_q <= st_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && in_valid_i) begin
      word_q <= in_word_i;
    end
  end

endmodule

`default_nettype wire

// ----- verif/tb_operator_number_lexer.sv -----
// Testbench for operator_number_lexer: streams characters in, predicts every token
// and checks each output word field by field. Depends on onl_pkg and the lexer RTL.
`timescale 1ns / 100ps

module tb_operator_number_lexer;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned PrintCap   = 100;
  localparam logic [63:0] ValueMax   = 64'h7FFF_FFFF_FFFF_FFFF;

  // Symbol spellings in code order; single characters have a zero upper byte
  localparam logic [15:0] SymSpell [37] = '{
    "++", "+=", "+", "--", "-=", "->", "-", "**", "*=", "*",
    "//", "/=", "/", "%%", "%=", "%", "<<", "<=", "<", ">>",
    ">=", ">", "==", "=>", "=", "!=", "!", "(", ")", "{",
    "}", "[", "]", ",", ";", ":", "."
  };

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  onl_pkg::in_word_t  in_word_i;
  logic               out_valid_o;
  logic               out_stall_i;
  onl_pkg::out_word_t out_word_o;

  operator_number_lexer uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  // Predicted lexer state
  onl_pkg::mode_e   lex_mode;
  logic [7:0]       held_char;
  onl_pkg::value_t  num_acc;
  onl_pkg::offset_t tok_start;
  onl_pkg::field_t  tok_len;
  onl_pkg::offset_t char_pos;

  onl_pkg::out_word_t tokens_due [$];
  onl_pkg::out_word_t step_tokens [$];

  int unsigned mismatch_count;
  int unsigned tokens_seen;
  int unsigned words_lexed;
  int unsigned cycle_count;
  int          hold_req;
  bit          gap_on;
  bit          stall_on;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- prediction

  function automatic bit is_blank(logic [7:0] c);
    return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic bit is_numeral(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  // key is {first, second} for a pair, {0, char} for a single symbol
  function automatic int find_sym(logic [15:0] key);
    for (int i = 0; i < 37; i++) begin
      if (SymSpell[i] == key) return i;
    end
    return -1;
  endfunction

  function automatic bit opens_pair(logic [7:0] c);
    for (int i = 0; i < 37; i++) begin
      if ((c != 8'h00) && (SymSpell[i][15:8] == c)) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic onl_pkg::out_word_t make_token(onl_pkg::kind_e k, int code,
                                                    onl_pkg::value_t v,
                                                    onl_pkg::offset_t s,
                                                    onl_pkg::field_t l);
    onl_pkg::out_word_t t;
    t.token_kind   = k;
    t.symbol_code  = 6'(code);
    t.number_value = v;
    t.start_offset = s;
    t.token_length = l;
    t.last_result  = 1'b0;
    return t;
  endfunction

  function automatic void reset_lexer();
    lex_mode  = onl_pkg::ModeIdle;
    held_char = '0;
    num_acc   = '0;
    tok_start = '0;
    tok_len   = '0;
    char_pos  = '0;
  endfunction

  function automatic void flush_held();
    if (lex_mode == onl_pkg::ModeSym) begin
      step_tokens.push_back(make_token(onl_pkg::KindSymbol, find_sym({8'h00, held_char}),
                                       '0, tok_start, 16'd1));
    end else if (lex_mode == onl_pkg::ModeNum) begin
      step_tokens.push_back(make_token(onl_pkg::KindNumber, 0, num_acc, tok_start,
                                       tok_len));
    end
    lex_mode = onl_pkg::ModeIdle;
  endfunction

  // A character seen with nothing held
  function automatic void lex_char(logic [7:0] c, onl_pkg::offset_t pos);
    int idx;
    idx = find_sym({8'h00, c});
    if (is_blank(c)) return;
    if (is_numeral(c)) begin
      lex_mode  = onl_pkg::ModeNum;
      num_acc   = onl_pkg::value_t'(c - "0");
      tok_start = pos;
      tok_len   = 16'd1;
    end else if (opens_pair(c)) begin
      lex_mode  = onl_pkg::ModeSym;
      held_char = c;
      tok_start = pos;
      tok_len   = 16'd1;
    end else if (idx >= 0) begin
      step_tokens.push_back(make_token(onl_pkg::KindSymbol, idx, '0, pos, 16'd1));
    end else begin
      step_tokens.push_back(make_token(onl_pkg::KindError, 0, '0, pos, 16'd1));
    end
  endfunction

  function automatic void lex_predict(onl_pkg::in_word_t w);
    int                 idx;
    onl_pkg::offset_t   pos;
    logic [63:0]        digit;
    onl_pkg::out_word_t tok;
    pos = char_pos;
    step_tokens.delete();
    if (w.is_end) begin
      flush_held();
      step_tokens.push_back(make_token(onl_pkg::KindEnd, 0, '0, pos, 16'd1));
      reset_lexer();
    end else begin
      if (char_pos != '1) char_pos++;
      case (lex_mode)
        onl_pkg::ModeSym: begin
          idx = find_sym({held_char, w.ch});
          if (idx >= 0) begin
            step_tokens.push_back(make_token(onl_pkg::KindSymbol, idx, '0, tok_start,
                                             16'd2));
            lex_mode = onl_pkg::ModeIdle;
          end else begin
            flush_held();
            lex_char(w.ch, pos);
          end
        end
        onl_pkg::ModeNum: begin
          if (is_numeral(w.ch)) begin
            digit = 64'(w.ch - "0");
            if ({1'b0, num_acc} > (ValueMax - digit) / 64'd10) num_acc = ValueMax[62:0];
            else num_acc = 63'({1'b0, num_acc} * 64'd10 + digit);
            if (tok_len != '1) tok_len++;
          end else begin
            flush_held();
            lex_char(w.ch, pos);
          end
        end
        default: lex_char(w.ch, pos);
      endcase
    end
    foreach (step_tokens[i]) begin
      tok = step_tokens[i];
      tok.last_result = (i == step_tokens.size() - 1);
      tokens_due.push_back(tok);
    end
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string what);
    if (mismatch_count < PrintCap) $display("%0t ns  %s", $time, what);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [62:0] got, logic [62:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("token %0d %s: got %0h, want %0h", tokens_seen, name,
                                got, want));
    end
  endtask

  initial begin : token_checker
    onl_pkg::out_word_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (tokens_due.size() == 0) begin
          report_mismatch($sformatf("token %0d arrived with none due: %0h", tokens_seen,
                                    out_word_o));
        end else begin
          want = tokens_due.pop_front();
          check_field("kind", 63'(out_word_o.token_kind), 63'(want.token_kind));
          check_field("symbol", 63'(out_word_o.symbol_code), 63'(want.symbol_code));
          check_field("value", out_word_o.number_value, want.number_value);
          check_field("start", 63'(out_word_o.start_offset), 63'(want.start_offset));
          check_field("length", 63'(out_word_o.token_length), 63'(want.token_length));
          check_field("last", 63'(out_word_o.last_result), 63'(want.last_result));
        end
        tokens_seen++;
      end
    end
  end

  // ---------------------------------------------------------------- output stalls

  initial begin : stall_gen
    int streak;
    int r;
    streak      = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req > 0) begin
        streak   = hold_req;
        hold_req = 0;
      end
      if (streak > 0) begin
        out_stall_i <= 1'b1;
        streak--;
      end else if (!stall_on) begin
        out_stall_i <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 4) streak = $urandom_range(5, 24);
        out_stall_i <= (r < 30);
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------- stimulus

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 20);
  endfunction

  // Offers one word and returns at the edge where it is taken; valid stays up
  task automatic send_word(logic [7:0] c, logic e);
    onl_pkg::in_word_t w;
    int                gap;
    w.ch     = c;
    w.is_end = e;
    gap      = gap_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    lex_predict(w);
    if (e || !is_blank(c)) words_lexed++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (tokens_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_sym(int idx);
    if (SymSpell[idx][15:8] != 8'h00) send_word(SymSpell[idx][15:8], 1'b0);
    send_word(SymSpell[idx][7:0], 1'b0);
  endtask

  task automatic send_random_token();
    int         r;
    int         n;
    logic [7:0] c;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      send_sym($urandom_range(0, 36));
      if ($urandom_range(0, 1) == 0) send_word(" ", 1'b0);
    end else if (r < 58) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 22) : $urandom_range(1, 5);
      repeat (n) send_word(8'("0" + $urandom_range(0, 9)), 1'b0);
    end else if (r < 68) begin
      repeat ($urandom_range(1, 3)) begin
        c = ($urandom_range(0, 5) == 0) ? " " : 8'($urandom_range(9, 13));
        send_word(c, 1'b0);
      end
    end else if (r < 77) begin
      do c = 8'($urandom_range(0, 255));
      while (is_blank(c) || is_numeral(c) || (find_sym({8'h00, c}) >= 0));
      send_word(c, 1'b0);
    end else if (r < 82) begin
      send_word(8'($urandom_range(0, 255)), 1'b1);
    end else if (r < 92) begin
      send_word(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      // symbol of pair-capable characters, then any symbol, which may or may not pair with it
      send_sym($urandom_range(0, 26));
      send_sym($urandom_range(0, 36));
    end
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_directed();
    gap_on   = 1'b1;
    stall_on = 1'b1;
    send_word(" ", 1'b0);
    send_word(8'd9, 1'b0);
    send_word(8'd13, 1'b0);
    send_text("+=");
    send_text("-5!(");            // broken lookahead, then '!' broken by '('
    send_word(8'hFF, 1'b0);
    send_word(8'h00, 1'b0);       // zero byte without the end flag is an error
    send_word(8'h80, 1'b0);
    send_text("07");
    send_word(8'hFF, 1'b1);       // flushes the number, then end
    send_word("+", 1'b1);         // end on an empty line
    send_word("<", 1'b0);
    send_word(8'h00, 1'b1);       // flushes a held symbol
    send_text("->=>=");
    send_word(8'h00, 1'b1);
  endtask

  task automatic test_saturation();
    gap_on   = 1'b0;
    stall_on = 1'b0;
    send_text("9223372036854775807 9223372036854775808 00018446744073709551616");
    send_word(8'h00, 1'b1);
    // long digit run stays pinned at the value ceiling
    repeat (40) send_word("9", 1'b0);
    send_text("++@-");
    send_word(8'h00, 1'b1);
    send_text("1");
    send_word(8'h00, 1'b1);
    wait_drained();
  endtask

  task automatic test_backpressure();
    gap_on   = 1'b0;
    stall_on = 1'b0;
    hold_req = 80;
    repeat (15) begin
      send_text("!(");
      send_word("$", 1'b0);
    end
    wait_drained();
    stall_on = 1'b1;
    hold_req = 40;
    repeat (20) send_text("<(");
    wait_drained();
  endtask

  task automatic test_random();
    int unsigned base;
    base = words_lexed;
    for (int seg = 0; seg < 10; seg++) begin
      gap_on   = (seg == 3) ? 1'b0 : 1'($urandom_range(0, 3) != 0);
      stall_on = (seg == 3) ? 1'b0 : 1'($urandom_range(0, 3) != 0);
      if (seg == 6) wait_drained();
      while (words_lexed - base < (seg + 1) * 62) send_random_token();
    end
    send_word(8'h00, 1'b1);
  endtask

  initial begin : main
    int waited;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_word_i      = '0;
    hold_req       = 0;
    gap_on         = 1'b0;
    stall_on       = 1'b0;
    mismatch_count = 0;
    tokens_seen    = 0;
    words_lexed    = 0;
    reset_lexer();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_saturation();
    test_backpressure();
    test_random();

    in_valid_i <= 1'b0;
    waited = 0;
    while ((tokens_due.size() != 0) && (waited < 5000)) begin
      @(posedge clk_i);
      waited++;
    end
    while (tokens_due.size() != 0) begin
      report_mismatch($sformatf("token never arrived: %0h", tokens_due.pop_front()));
    end
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
